@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the core RTL.
// Depends on aclk and aresetn being in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, idle during reset
`define BBF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication shorthand
`define BBF_ASSERT_IMPL(lbl, pre, post, msg) \
    `BBF_ASSERT(lbl, (pre) |-> (post), msg)

`endif

@@ rtl/core/bbf_pkg.sv @@
// Shared types and constants for the banked Bloom filter core.
// No dependencies.
package bbf_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_IGNORE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOAD,
        BK_DIV,
        BK_READ,
        BK_UPDATE,
        BK_FINISH
    } back_state_t;

    localparam logic CFG_HASH_COUNT = 1'b0;
    localparam logic CFG_BANK_BYTES = 1'b1;

    localparam logic [4:0]  HASH_COUNT_RST = 5'd6;
    localparam logic [11:0] BANK_BYTES_RST = 12'd2048;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] SEEDS [16] = '{
        32'd217636919,  32'd290182597,  32'd386910137,  32'd515880193,
        32'd687840301,  32'd917120411,  32'd1222827239, 32'd1610612741,
        32'd3300450239, 32'd3300450259, 32'd3300450281, 32'd3300450289,
        32'd3221225473, 32'd4294967291, 32'd163227661,  32'd122420729
    };

endpackage

@@ rtl/core/bbf_front.sv @@
// Front end: takes key bytes, updates all hash accumulators, hands finished keys and clear ops on.
// Depends on bbf_pkg.
module bbf_front import bbf_pkg::*; #(
    parameter int HASH_SLOTS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // key_byte
    input  logic [1:0]                 s_tuser,   // op
    input  logic                       s_tlast,   // last_byte
    input  logic                       hold,
    input  logic                       q_full,
    output logic                       q_push,
    output logic [HASH_SLOTS*64+1:0]   q_data
);

    logic [63:0] acc_reg [HASH_SLOTS];
    logic [63:0] lo_reg  [HASH_SLOTS];
    logic [31:0] hi_reg  [HASH_SLOTS];
    logic [63:0] h_next  [HASH_SLOTS];
    logic        st_valid_reg;
    logic [1:0]  st_op_reg;
    logic [7:0]  st_byte_reg;
    logic        st_last_reg;
    logic        accept;
    logic        is_key;

    assign s_tready = !st_valid_reg && !q_full && !hold;
    assign accept   = s_tvalid && s_tready;
    assign is_key   = (st_op_reg == OP_INSERT) || (st_op_reg == OP_QUERY);

    always_comb begin
        for (int i = 0; i < HASH_SLOTS; i++) begin
            h_next[i] = lo_reg[i] + {hi_reg[i], 32'd0} + {56'd0, st_byte_reg};
        end
    end

    assign q_push = st_valid_reg && ((st_op_reg == OP_CLEAR) || (is_key && st_last_reg));

    always_comb begin
        q_data[1:0] = st_op_reg;
        for (int i = 0; i < HASH_SLOTS; i++) begin
            q_data[2 + 64*i +: 64] = h_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            for (int i = 0; i < HASH_SLOTS; i++) begin
                acc_reg[i] <= '0;
            end
        end else begin
            st_valid_reg <= accept;
            if (st_valid_reg) begin
                case (st_op_reg)
                    OP_CLEAR: begin
                        for (int i = 0; i < HASH_SLOTS; i++) acc_reg[i] <= '0;
                    end
                    OP_INSERT, OP_QUERY: begin
                        for (int i = 0; i < HASH_SLOTS; i++) begin
                            acc_reg[i] <= st_last_reg ? 64'd0 : h_next[i];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_op_reg   <= s_tuser;
            st_byte_reg <= s_tdata;
            st_last_reg <= s_tlast;
            for (int i = 0; i < HASH_SLOTS; i++) begin
                lo_reg[i] <= {32'd0, acc_reg[i][31:0]} * {32'd0, SEEDS[i]};
                hi_reg[i] <= acc_reg[i][63:32] * SEEDS[i];
            end
        end
    end

endmodule

@@ rtl/core/bbf_queue.sv @@
// Short FIFO between front and back end.
// Depends on bbf_pkg.
module bbf_queue import bbf_pkg::*; #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] pop_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/bbf_back.sv @@
// Back end: remainder unit, bitmap memory, key counter and result register.
// Depends on bbf_pkg.
module bbf_back import bbf_pkg::*; #(
    parameter int HASH_SLOTS       = 16,
    parameter int BANK_SELECT_BITS = 6,
    parameter int BANK_BYTES_MAX   = 2048
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [4:0]                hash_count,
    input  logic [11:0]               bank_bytes,
    input  logic                      q_valid,
    input  logic [HASH_SLOTS*64+1:0]  q_data,
    output logic                      q_pop,
    output logic                      clearing,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic                      out_present,
    output logic [31:0]               out_count
);

    localparam int BS   = BANK_SELECT_BITS;
    localparam int SW   = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1;
    localparam int SCW  = $clog2(HASH_SLOTS + 1);
    localparam int BBW  = $clog2(BANK_BYTES_MAX + 1);
    localparam int MODW = BBW + 3;
    localparam int IDXW = (BANK_BYTES_MAX > 1) ? $clog2(BANK_BYTES_MAX) : 1;
    localparam int AW   = BS + IDXW;
    localparam int DW   = 64 - BS;
    localparam int CW   = $clog2(DW + 1);

    back_state_t     state_reg, state_next;
    op_t             op_reg, op_next;
    logic [63:0]     hash_reg [HASH_SLOTS];
    logic            load_hashes;
    logic [SCW-1:0]  slot_reg, slot_next;
    logic [MODW-1:0] rem_reg, rem_next;
    logic [DW-1:0]   div_reg, div_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [BS-1:0]   bank_reg, bank_next;
    logic            all_set_reg, all_set_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [31:0]     count_reg, count_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_present_reg, out_present_next;
    logic [31:0]     out_count_reg, out_count_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [2:0]      bit_reg, bit_next;
    logic [7:0]      rd_data_reg;

    logic [7:0]      mem [2**AW];
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata;

    logic [SCW-1:0]  n_eff;
    logic [BBW-1:0]  bb_eff;
    logic [MODW-1:0] modulus;
    logic [MODW:0]   trial;
    logic [63:0]     h_sel;

    always_comb begin
        if (hash_count == '0) begin
            n_eff = SCW'(1);
        end else if (32'(hash_count) > 32'(HASH_SLOTS)) begin
            n_eff = SCW'(HASH_SLOTS);
        end else begin
            n_eff = SCW'(hash_count);
        end
        if (bank_bytes == '0) begin
            bb_eff = BBW'(1);
        end else if (32'(bank_bytes) > 32'(BANK_BYTES_MAX)) begin
            bb_eff = BBW'(BANK_BYTES_MAX);
        end else begin
            bb_eff = BBW'(bank_bytes);
        end
    end

    assign modulus  = {bb_eff, 3'b000};
    assign trial    = {rem_reg, div_reg[DW-1]};
    assign h_sel    = hash_reg[slot_reg[SW-1:0]];
    assign clearing = (state_reg == BK_CLEAR);
    assign m_tvalid    = out_valid_reg;
    assign out_present = out_present_reg;
    assign out_count   = out_count_reg;

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        slot_next        = slot_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        cnt_next         = cnt_reg;
        bank_next        = bank_reg;
        all_set_next     = all_set_reg;
        clr_addr_next    = clr_addr_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_present_next = out_present_reg;
        out_count_next   = out_count_reg;
        addr_next        = addr_reg;
        bit_next         = bit_reg;
        q_pop            = 1'b0;
        load_hashes      = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = clr_addr_reg;
        mem_raddr        = {bank_reg, rem_reg[IDXW+2:3]};
        mem_wdata        = '0;

        case (state_reg)
            BK_CLEAR: begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_data[1:0] == OP_CLEAR) begin
                        count_next    = '0;
                        clr_addr_next = '0;
                        state_next    = BK_CLEAR;
                    end else begin
                        op_next      = op_t'(q_data[1:0]);
                        load_hashes  = 1'b1;
                        slot_next    = '0;
                        all_set_next = 1'b1;
                        state_next   = BK_LOAD;
                    end
                end
            end
            BK_LOAD: begin
                bank_next  = h_sel[BS-1:0];
                div_next   = h_sel[63:BS];
                rem_next   = '0;
                cnt_next   = CW'(DW);
                state_next = BK_DIV;
            end
            BK_DIV: begin
                if (trial >= {1'b0, modulus}) begin
                    rem_next = MODW'(trial - {1'b0, modulus});
                end else begin
                    rem_next = MODW'(trial);
                end
                div_next = div_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = BK_READ;
                end
            end
            BK_READ: begin
                mem_re     = 1'b1;
                addr_next  = mem_raddr;
                bit_next   = rem_reg[2:0];
                state_next = BK_UPDATE;
            end
            BK_UPDATE: begin
                if (op_reg == OP_INSERT) begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_reg;
                    mem_wdata = rd_data_reg | (8'd1 << bit_reg);
                end else if (!rd_data_reg[bit_reg]) begin
                    all_set_next = 1'b0;
                end
                slot_next = slot_reg + 1'b1;
                if (slot_reg + 1'b1 == n_eff) begin
                    state_next = BK_FINISH;
                end else begin
                    state_next = BK_LOAD;
                end
            end
            BK_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_INSERT) begin
                        if (count_reg != '1) begin
                            count_next = count_reg + 1'b1;
                        end
                        out_present_next = 1'b0;
                        out_count_next   = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
                    end else begin
                        out_present_next = all_set_reg;
                        out_count_next   = count_reg;
                    end
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        slot_reg        <= slot_next;
        rem_reg         <= rem_next;
        div_reg         <= div_next;
        cnt_reg         <= cnt_next;
        bank_reg        <= bank_next;
        all_set_reg     <= all_set_next;
        out_present_reg <= out_present_next;
        out_count_reg   <= out_count_next;
        addr_reg        <= addr_next;
        bit_reg         <= bit_next;
        if (load_hashes) begin
            for (int i = 0; i < HASH_SLOTS; i++) begin
                hash_reg[i] <= q_data[2 + 64*i +: 64];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

@@ rtl/core/banked_bloom_filter_core.sv @@
// Banked Bloom filter with multiplicative byte hashes: top level, config registers.
// Depends on bbf_pkg, bbf_front, bbf_queue, bbf_back and assert_macros.svh.
//
// Key bytes are taken one at a time: a new byte is accepted only after the
// previous one has passed the two-stage accumulator multiply. A finished key
// queues for the back end, which takes the next key only once done with the
// last; its time per key is set by the bit-serial remainder unit (one
// quotient bit per cycle) and the read-modify-write of the bitmap. After
// reset and after every clear op the bitmap is wiped one byte per cycle, all
// 2^(BANK_SELECT_BITS + clog2(BANK_BYTES_MAX)) bytes (131072 at defaults),
// during which s_tready stays low; config writes are taken at any time.
`include "assert_macros.svh"

module banked_bloom_filter_core import bbf_pkg::*; #(
    parameter int HASH_SLOTS       = 16,
    parameter int BANK_SELECT_BITS = 6,
    parameter int BANK_BYTES_MAX   = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] present, [32:1] key_count, rest zero
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [11:0] cfg_wdata
);

    localparam int QW = HASH_SLOTS * 64 + 2;

    logic [4:0]    hash_count_reg;
    logic [11:0]   bank_bytes_reg;
    logic          q_push, q_full, q_pop, q_valid, clearing;
    logic [QW-1:0] q_in, q_out;
    logic          out_present;
    logic [31:0]   out_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_count_reg <= HASH_COUNT_RST;
            bank_bytes_reg <= BANK_BYTES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HASH_COUNT: hash_count_reg <= cfg_wdata[4:0];
                CFG_BANK_BYTES: bank_bytes_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bbf_front #(.HASH_SLOTS(HASH_SLOTS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .hold     (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    bbf_queue #(.W(QW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    bbf_back #(
        .HASH_SLOTS       (HASH_SLOTS),
        .BANK_SELECT_BITS (BANK_SELECT_BITS),
        .BANK_BYTES_MAX   (BANK_BYTES_MAX)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hash_count  (hash_count_reg),
        .bank_bytes  (bank_bytes_reg),
        .q_valid     (q_valid),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_present (out_present),
        .out_count   (out_count)
    );

    assign m_tdata = {7'd0, out_count, out_present};

    `BBF_ASSERT_IMPL(a_no_accept_in_clear, clearing, !s_tready, "word accepted during clear")
    `BBF_ASSERT(a_no_queue_overflow, !(q_push && q_full), "queue overflow")
    `BBF_ASSERT_IMPL(a_pop_needs_data, q_pop, q_valid, "pop from empty queue")
    `BBF_ASSERT_IMPL(a_front_spacing, s_tvalid && s_tready, ##1 !s_tready,
        "front accepted back to back")

endmodule
